// ===== hw/rtl/slxd_pkg.sv =====
// ----------------------------------------------------------------------------
// slxd_pkg
// Shared types and constants for the sync/length/XOR deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package slxd_pkg;

   // Register map, index of each register (byte address is 4 times this).
   localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
   localparam logic [1:0] REG_FULL_FRAME  = 2'd2;
   localparam int         ADDR_W          = 4;

   // Deframer phases.
   localparam logic [1:0] PH_HUNT1 = 2'd0;
   localparam logic [1:0] PH_HUNT2 = 2'd1;
   localparam logic [1:0] PH_LEN   = 2'd2;
   localparam logic [1:0] PH_BODY  = 2'd3;

   // Frame status codes.
   localparam logic [1:0] ST_BUSY = 2'd0;
   localparam logic [1:0] ST_OK   = 2'd1;
   localparam logic [1:0] ST_CSUM = 2'd2;
   localparam logic [1:0] ST_LEN  = 2'd3;

   // Smallest legal length byte (one body byte plus the checksum).
   localparam logic [7:0] MIN_LEN = 8'd2;

   // Result queue, in entries; each entry holds up to two result words.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic       full_frame;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       frame_first;
      logic       frame_last;
      logic [1:0] frame_status;
   } result_type;

   typedef struct packed {
      logic       two;
      result_type res0;
      result_type res1;
   } entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/slxd_csr.sv =====
// ----------------------------------------------------------------------------
// slxd_csr
// APB-style configuration registers of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

module slxd_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [slxd_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                pwdata,
   output      logic [31:0]                prdata,
   output      logic                       pready,
   output      slxd_pkg::cfg_type          cfg
);
   import slxd_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SYNC_FIRST:  cfg_in.sync_first  = pwdata[7:0];
            REG_SYNC_SECOND: cfg_in.sync_second = pwdata[7:0];
            REG_FULL_FRAME:  cfg_in.full_frame  = pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SYNC_FIRST:  prdata = {24'd0, cfg_ff.sync_first};
         REG_SYNC_SECOND: prdata = {24'd0, cfg_ff.sync_second};
         REG_FULL_FRAME:  prdata = {31'd0, cfg_ff.full_frame};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/slxd_core.sv =====
// ----------------------------------------------------------------------------
// slxd_core
// Per-byte deframing state machine; yields up to two result words per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module slxd_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire slxd_pkg::cfg_type   cfg,
   input  wire logic                in_valid,
   input  wire logic [7:0]          in_byte,
   output      logic                push,
   output      slxd_pkg::entry_type push_entry
);
   import slxd_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] left_ff, left_in;
   logic [1:0] sum_status;

   assign sum_status = (in_byte == xor_ff) ? ST_OK : ST_CSUM;

   always_comb begin
      phase_in   = phase_ff;
      xor_in     = xor_ff;
      left_in    = left_ff;
      push       = 1'b0;
      push_entry = '0;
      if (in_valid) begin
         unique case (phase_ff)
            PH_HUNT1: begin
               if (in_byte == cfg.sync_first) begin
                  xor_in   = in_byte;
                  phase_in = PH_HUNT2;
               end
            end
            PH_HUNT2: begin
               if (in_byte == cfg.sync_second) begin
                  xor_in   = xor_ff ^ in_byte;
                  phase_in = PH_LEN;
                  if (cfg.full_frame) begin
                     push            = 1'b1;
                     push_entry.two  = 1'b1;
                     push_entry.res0 = '{xor_ff, 1'b1, 1'b1, 1'b0, ST_BUSY};
                     push_entry.res1 = '{in_byte, 1'b1, 1'b0, 1'b0, ST_BUSY};
                  end
               end else if (in_byte == cfg.sync_first) begin
                  xor_in = in_byte;
               end else begin
                  phase_in = PH_HUNT1;
                  xor_in   = 8'd0;
                  left_in  = 8'd0;
               end
            end
            PH_LEN: begin
               push = 1'b1;
               if (in_byte < MIN_LEN) begin
                  phase_in = PH_HUNT1;
                  xor_in   = 8'd0;
                  left_in  = 8'd0;
                  if (cfg.full_frame) begin
                     push_entry.res0 = '{in_byte, 1'b1, 1'b0, 1'b1, ST_LEN};
                  end else begin
                     push_entry.res0 = '{8'd0, 1'b0, 1'b1, 1'b1, ST_LEN};
                  end
               end else begin
                  xor_in   = xor_ff ^ in_byte;
                  left_in  = in_byte;
                  phase_in = PH_BODY;
                  if (cfg.full_frame) begin
                     push_entry.res0 = '{in_byte, 1'b1, 1'b0, 1'b0, ST_BUSY};
                  end else begin
                     push_entry.res0 = '{in_byte - 8'd1, 1'b1, 1'b1, 1'b0, ST_BUSY};
                  end
               end
            end
            PH_BODY: begin
               push = 1'b1;
               if (left_ff <= 8'd1) begin
                  phase_in = PH_HUNT1;
                  xor_in   = 8'd0;
                  left_in  = 8'd0;
                  if (cfg.full_frame) begin
                     push_entry.res0 = '{in_byte, 1'b1, 1'b0, 1'b1, sum_status};
                  end else begin
                     push_entry.res0 = '{8'd0, 1'b0, 1'b0, 1'b1, sum_status};
                  end
               end else begin
                  left_in         = left_ff - 8'd1;
                  xor_in          = xor_ff ^ in_byte;
                  push_entry.res0 = '{in_byte, 1'b1, 1'b0, 1'b0, ST_BUSY};
               end
            end
            default: begin
               phase_in = PH_HUNT1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         xor_ff   <= 8'd0;
         left_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         xor_ff   <= xor_in;
         left_ff  <= left_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/slxd_fifo.sv =====
// ----------------------------------------------------------------------------
// slxd_fifo
// Result queue; each entry holds one or two result words, drained in order.
// ----------------------------------------------------------------------------
`default_nettype none

module slxd_fifo (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   input  wire slxd_pkg::entry_type             push_entry,
   output      logic [slxd_pkg::FIFO_CNT_W-1:0] count,
   output      logic                            out_valid,
   input  wire logic                            out_ready,
   output      slxd_pkg::result_type            out_result
);
   import slxd_pkg::*;

   entry_type             entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  sub_ff, sub_in;
   entry_type             head;
   logic                  fire;
   logic                  pop;

   assign head       = entries_ff[rd_ptr_ff];
   assign out_valid  = (count_ff != '0);
   assign out_result = sub_ff ? head.res1 : head.res0;
   assign fire       = out_valid & out_ready;
   assign pop        = fire & (sub_ff | ~head.two);
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push & ~pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (pop & ~push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
      sub_in = sub_ff;
      if (fire) begin
         sub_in = ~sub_ff & head.two;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sync_length_xor_deframer_top.sv =====
// ----------------------------------------------------------------------------
// sync_length_xor_deframer_top
// Byte-stream deframer: two sync bytes, a length byte, XOR checksum.
// ----------------------------------------------------------------------------
// The block takes one received byte per word on the req channel and can accept
// a new byte in every clock cycle while req_ready is high. A byte is captured
// in an input register, run through the per-byte deframing logic in the
// following cycle, and its results are written into a four-entry result queue
// that drives the rsp channel. Each byte yields zero, one or two result words:
// in full mode the second sync byte releases both sync bytes at once, so the
// rsp side drains those two words one after the other. An accepted byte passes
// through the input register and the result queue before its first result
// word reaches the rsp side. The req side is held off only when the queue
// could not hold the results of the byte in the input register plus one more,
// so a stalled consumer backs up into req_ready. The sync bytes and the
// full_frame mode bit are set through the APB-style port at byte addresses
// 0, 4 and 8 and should be changed only while the block is idle.
`default_nettype none

module sync_length_xor_deframer_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // Configuration port.
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [slxd_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output      logic [31:0]                 prdata,
   output      logic                        pready,
   // Received byte stream.
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [7:0]                  req_rx_byte,
   // Frame results.
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [7:0]                  rsp_out_byte,
   output      logic                        rsp_byte_valid,
   output      logic                        rsp_frame_first,
   output      logic                        rsp_frame_last,
   output      logic [1:0]                  rsp_frame_status
);
   import slxd_pkg::*;

   cfg_type               cfg;
   logic                  stage_valid_ff, stage_valid_in;
   logic [7:0]            stage_byte_ff, stage_byte_in;
   logic                  push;
   entry_type             push_entry;
   logic [FIFO_CNT_W-1:0] count;
   result_type            result;
   logic [FIFO_CNT_W:0]   reserved;

   // The byte in the input register takes one queue entry this cycle, and a
   // byte accepted now takes one more next cycle; the pop side is not counted.
   assign reserved  = {1'b0, count} + {{FIFO_CNT_W{1'b0}}, stage_valid_ff};
   assign req_ready = (reserved < (FIFO_CNT_W + 1)'(FIFO_DEPTH));

   assign stage_valid_in = req_valid & req_ready;
   assign stage_byte_in  = req_rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // The byte register carries payload only and needs no reset.
   always_ff @(posedge clock) begin
      if (stage_valid_in) begin
         stage_byte_ff <= stage_byte_in;
      end
   end

   slxd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   slxd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (stage_valid_ff),
      .in_byte    (stage_byte_ff),
      .push       (push),
      .push_entry (push_entry)
   );

   slxd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .count      (count),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   assign rsp_out_byte     = result.out_byte;
   assign rsp_byte_valid   = result.byte_valid;
   assign rsp_frame_first  = result.frame_first;
   assign rsp_frame_last   = result.frame_last;
   assign rsp_frame_status = result.frame_status;

endmodule

`default_nettype wire

// ===== bench/slxd_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slxd_frame_checker
// Watches the register port and both word channels of the deframer, keeps its
// own copy of the deframing state, and compares every result word.
// ----------------------------------------------------------------------------
module slxd_frame_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [slxd_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   input  wire logic                        pready,
   input  wire logic                        req_valid,
   input  wire logic                        req_ready,
   input  wire logic [7:0]                  req_rx_byte,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire logic [7:0]                  rsp_out_byte,
   input  wire logic                        rsp_byte_valid,
   input  wire logic                        rsp_frame_first,
   input  wire logic                        rsp_frame_last,
   input  wire logic [1:0]                  rsp_frame_status,
   output int                               mismatches,
   output int                               words_due,
   output int                               words_seen,
   output int                               frames_ok,
   output int                               frames_bad_sum,
   output int                               frames_bad_len
);
   import slxd_pkg::*;

   logic [7:0] cfg_sync_first;
   logic [7:0] cfg_sync_second;
   logic       cfg_full;
   logic [1:0] phase_now;
   logic [7:0] xor_acc;
   logic [7:0] bytes_due;
   result_type due_words[$];

   function automatic result_type make_word(input logic [7:0] b, input logic v,
                                            input logic f, input logic l,
                                            input logic [1:0] st);
      result_type w;
      w.out_byte     = b;
      w.byte_valid   = v;
      w.frame_first  = f;
      w.frame_last   = l;
      w.frame_status = st;
      return w;
   endfunction

   task automatic restart_hunt();
      phase_now = PH_HUNT1;
      xor_acc   = '0;
      bytes_due = '0;
   endtask

   // Advances the deframing state by one received byte and queues the words
   // that byte must produce.
   task automatic deframe_byte(input logic [7:0] b);
      logic [1:0] st;
      case (phase_now)
         PH_HUNT1: begin
            if (b == cfg_sync_first) begin
               xor_acc   = b;
               phase_now = PH_HUNT2;
            end
         end
         PH_HUNT2: begin
            if (b == cfg_sync_second) begin
               if (cfg_full) begin
                  due_words.push_back(make_word(xor_acc, 1'b1, 1'b1, 1'b0, ST_BUSY));
                  due_words.push_back(make_word(b, 1'b1, 1'b0, 1'b0, ST_BUSY));
               end
               xor_acc   = xor_acc ^ b;
               phase_now = PH_LEN;
            end else if (b == cfg_sync_first) begin
               xor_acc = b;
            end else begin
               restart_hunt();
            end
         end
         PH_LEN: begin
            if (b < MIN_LEN) begin
               restart_hunt();
               if (cfg_full)
                  due_words.push_back(make_word(b, 1'b1, 1'b0, 1'b1, ST_LEN));
               else
                  due_words.push_back(make_word(8'h00, 1'b0, 1'b1, 1'b1, ST_LEN));
            end else begin
               xor_acc   = xor_acc ^ b;
               bytes_due = b;
               phase_now = PH_BODY;
               if (cfg_full)
                  due_words.push_back(make_word(b, 1'b1, 1'b0, 1'b0, ST_BUSY));
               else
                  due_words.push_back(make_word(b - 8'd1, 1'b1, 1'b1, 1'b0, ST_BUSY));
            end
         end
         default: begin
            if (bytes_due <= 8'd1) begin
               st = (b == xor_acc) ? ST_OK : ST_CSUM;
               restart_hunt();
               if (cfg_full)
                  due_words.push_back(make_word(b, 1'b1, 1'b0, 1'b1, st));
               else
                  due_words.push_back(make_word(8'h00, 1'b0, 1'b0, 1'b1, st));
            end else begin
               bytes_due = bytes_due - 8'd1;
               xor_acc   = xor_acc ^ b;
               due_words.push_back(make_word(b, 1'b1, 1'b0, 1'b0, ST_BUSY));
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         cfg_sync_first  = '0;
         cfg_sync_second = '0;
         cfg_full        = 1'b0;
         restart_hunt();
         due_words.delete();
         mismatches      = 0;
         words_seen      = 0;
         frames_ok       = 0;
         frames_bad_sum  = 0;
         frames_bad_len  = 0;
         words_due      <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_SYNC_FIRST:  cfg_sync_first  = pwdata[7:0];
               REG_SYNC_SECOND: cfg_sync_second = pwdata[7:0];
               REG_FULL_FRAME:  cfg_full        = pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            deframe_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            if (due_words.size() == 0) begin
               report_mismatch("word with nothing due, out_byte", int'(rsp_out_byte), 0);
            end else begin
               want = due_words.pop_front();
               words_seen++;
               if (rsp_out_byte != want.out_byte)
                  report_mismatch("out_byte", int'(rsp_out_byte), int'(want.out_byte));
               if (rsp_byte_valid != want.byte_valid)
                  report_mismatch("byte_valid", int'(rsp_byte_valid),
                                  int'(want.byte_valid));
               if (rsp_frame_first != want.frame_first)
                  report_mismatch("frame_first", int'(rsp_frame_first),
                                  int'(want.frame_first));
               if (rsp_frame_last != want.frame_last)
                  report_mismatch("frame_last", int'(rsp_frame_last),
                                  int'(want.frame_last));
               if (rsp_frame_status != want.frame_status)
                  report_mismatch("frame_status", int'(rsp_frame_status),
                                  int'(want.frame_status));
               if (want.frame_last) begin
                  case (want.frame_status)
                     ST_OK:   frames_ok++;
                     ST_CSUM: frames_bad_sum++;
                     default: frames_bad_len++;
                  endcase
               end
            end
         end
         words_due <= due_words.size();
      end
   end

endmodule

// ===== bench/tb_sync_length_xor_deframer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_length_xor_deframer_top
// Drives byte streams and register settings into the deframer; a separate
// frame checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_sync_length_xor_deframer_top;
   import slxd_pkg::*;

   // Guard against a hung run; the slowest legal run (every byte after the
   // longest sender gap, every result word behind the longest receiver stall)
   // stays under this limit.
   localparam int LIMIT_CYCLES  = 2000000;
   // Cycles allowed after the last due word: covers the input register and the
   // deframing logic for bytes that produce no word at all.
   localparam int SETTLE_CYCLES = 8;
   // Length of the deliberate receiver hold-off that backs up the req side.
   localparam int HOLD_CYCLES   = 400;
   // Frame bytes for the random part, spread over the register settings.
   localparam int BYTE_BUDGET   = 1250;
   localparam int NUM_SETTINGS  = 8;
   // Register index with nothing behind it; writes there must be ignored.
   localparam logic [1:0] REG_SPARE = 2'd3;

   logic              clock;
   logic              reset       = 1'b1;
   logic              psel        = 1'b0;
   logic              penable     = 1'b0;
   logic              pwrite      = 1'b0;
   logic [ADDR_W-1:0] paddr       = '0;
   logic [31:0]       pwdata      = '0;
   logic [31:0]       prdata;
   logic              pready;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic [7:0]        req_rx_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   logic [7:0]        rsp_out_byte;
   logic              rsp_byte_valid;
   logic              rsp_frame_first;
   logic              rsp_frame_last;
   logic [1:0]        rsp_frame_status;

   int mismatches;
   int words_due;
   int words_seen;
   int frames_ok;
   int frames_bad_sum;
   int frames_bad_len;

   int cycles      = 0;
   int frame_bytes = 0;
   int frames_sent = 0;

   // Sync bytes currently programmed; used only to build frames.
   logic [7:0] cur_sync_first  = '0;
   logic [7:0] cur_sync_second = '0;

   // Traffic shaping: a calm side never idles, and hold_now asks the
   // receiver for one long hold-off.
   bit sender_calm   = 1'b0;
   bit receiver_calm = 1'b0;
   bit hold_now      = 1'b0;

   sync_length_xor_deframer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_frame_first  (rsp_frame_first),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_status (rsp_frame_status)
   );

   slxd_frame_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_frame_first  (rsp_frame_first),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_status (rsp_frame_status),
      .mismatches       (mismatches),
      .words_due        (words_due),
      .words_seen       (words_seen),
      .frames_ok        (frames_ok),
      .frames_bad_sum   (frames_bad_sum),
      .frames_bad_len   (frames_bad_len)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a run that never drains its due words ends here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles with %0d words still due.", cycles, words_due);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int pick_gap(input bit calm);
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // One register write: a setup phase, an access phase, then an idle phase with
   // the port released so that back-to-back writes never overlap.
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Programs all three registers. Bits above each register's width carry
   // random junk, which the block has to drop.
   task automatic apply_setting(input logic [7:0] sf, input logic [7:0] ss,
                                input logic full);
      csr_write(REG_SYNC_FIRST,  ($urandom & 32'hFFFF_FF00) | sf);
      csr_write(REG_SYNC_SECOND, ($urandom & 32'hFFFF_FF00) | ss);
      csr_write(REG_FULL_FRAME,  ($urandom & 32'hFFFF_FFFE) | full);
      cur_sync_first  = sf;
      cur_sync_second = ss;
   endtask

   // Offers one byte after a random gap and returns at the edge where it was
   // taken. Valid is left high so that the next byte can follow directly.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // A well-formed frame with a random body. Lengths below two end after the
   // length byte; a corrupted frame gets a checksum that is always wrong.
   task automatic send_frame(input int len, input bit corrupt);
      logic [7:0] csum;
      logic [7:0] b;
      logic [7:0] flip;
      int         k;
      csum = cur_sync_first ^ cur_sync_second ^ len[7:0];
      send_byte(cur_sync_first);
      send_byte(cur_sync_second);
      send_byte(len[7:0]);
      if (len >= MIN_LEN) begin
         for (k = 1; k < len; k++) begin
            b    = 8'($urandom);
            csum = csum ^ b;
            send_byte(b);
         end
         flip = 8'($urandom_range(1, 255));
         send_byte(corrupt ? csum ^ flip : csum);
      end
      frames_sent++;
      frame_bytes += (len >= MIN_LEN) ? len + 3 : 3;
   endtask

   // Drops valid, waits for every due word to come back, then lets the
   // pipeline settle so that bytes with no word have also gone through.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly good frames with random content; the rest is noise, a sync byte
   // that is not followed up, frames with bad lengths, and frames cut short
   // so that the next frame is swallowed as body.
   task automatic random_traffic(input int quota);
      int stop_at;
      int pick;
      int r;
      int len;
      int k;
      stop_at = frame_bytes + quota;
      while (frame_bytes < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            r = $urandom_range(0, 99);
            if (r < 1)
               len = $urandom_range(128, 255);
            else if (r < 15)
               len = $urandom_range(9, 40);
            else
               len = $urandom_range(2, 8);
            send_frame(len, $urandom_range(0, 3) == 0);
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else if (pick < 88) begin
            send_byte(cur_sync_first);
            send_byte(8'($urandom));
         end else if (pick < 94) begin
            send_frame($urandom_range(0, 1), 1'b0);
         end else begin
            send_byte(cur_sync_first);
            send_byte(cur_sync_second);
            len = $urandom_range(5, 20);
            send_byte(len[7:0]);
            for (k = 0; k < $urandom_range(0, 3); k++)
               send_byte(8'($urandom));
         end
      end
   endtask

   // Receiver: runs of ready broken by random stalls, plus one long hold-off
   // when the stimulus asks for it. The hold-off is counted here, in cycles,
   // while the sender keeps offering bytes.
   initial begin : receiver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_now) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_now = 1'b0;
         end else begin
            stall = pick_gap(receiver_calm);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int         setting;
      logic [7:0] sf;
      logic [7:0] ss;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, full mode with extreme sync bytes. A write to the
      // spare index must change nothing. Noise, then a repeated first sync
      // byte that keeps the hunt armed, the sync pair that releases two
      // words at once, and a length of one that ends the frame at once.
      apply_setting(8'hFF, 8'h00, 1'b1);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      send_byte(8'h55);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h01);
      send_frame(2, 1'b0);
      wait_idle();

      // Strip mode with equal sync bytes: a zero length, a bad checksum
      // after which the hunt restarts on the very next byte, a broken sync
      // pair, and a good frame whose checksum word carries no byte.
      apply_setting(8'hA5, 8'hA5, 1'b0);
      send_frame(0, 1'b0);
      send_frame(3, 1'b1);
      send_byte(8'hA5);
      send_byte(8'h12);
      send_frame(2, 1'b0);

      // Random part over several settings, the extremes first. Setting 4
      // runs the sender flat out against a long receiver hold-off so the
      // result queue fills and req_ready drops; setting 5 has no idling on
      // either side.
      for (setting = 0; setting < NUM_SETTINGS; setting++) begin
         wait_idle();
         case (setting)
            0: apply_setting(8'h00, 8'h00, 1'b0);
            1: apply_setting(8'hFF, 8'hFF, 1'b1);
            2: apply_setting(8'h00, 8'hFF, 1'b1);
            3: apply_setting(8'hFF, 8'h00, 1'b0);
            default: begin
               sf = 8'($urandom);
               ss = ($urandom_range(0, 3) == 0) ? sf : 8'($urandom);
               apply_setting(sf, ss, 1'($urandom_range(0, 1)));
            end
         endcase
         sender_calm   = (setting == 4 || setting == 5);
         receiver_calm = (setting == 5);
         if (setting == 4)
            hold_now = 1'b1;
         // The longest legal frame, once, in full mode.
         if (setting == 1)
            send_frame(255, 1'b0);
         random_traffic(BYTE_BUDGET / NUM_SETTINGS);
      end
      wait_idle();

      $display("Sent %0d frames (%0d frame bytes) under %0d register settings; %0d words checked.",
               frames_sent, frame_bytes, NUM_SETTINGS + 2, words_seen);
      $display("Frames closed: %0d good, %0d bad checksum, %0d bad length; %0d mismatches.",
               frames_ok, frames_bad_sum, frames_bad_len, mismatches);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
